// ----- hdl/dcf_pkg.sv -----
`default_nettype none

package dcf_pkg;

  localparam int DCF_DEPTH  = 32;
  localparam int CODE_W     = 32;
  localparam int MS_W       = 16;
  localparam int FILL_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_CODE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_CODE      = 2'd3;

  localparam logic [MS_W-1:0]   FILTER_TIME_RST    = 16'd300;
  localparam logic [MS_W-1:0]   PAUSE_INTERVAL_RST = 16'd10000;
  localparam logic [CODE_W-1:0] EMPTY_CODE_RST     = 32'h0000_0000;
  localparam logic [CODE_W-1:0] IDLE_CODE_RST      = 32'hFFFF_FFFF;
  localparam logic [MS_W-1:0]   MS_MAX             = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CODE_W-1:0] code;
  } dcf_in_t;

  typedef struct packed {
    logic              read_valid;
    logic [CODE_W-1:0] read_code;
    logic              was_empty;
    logic              pushed;
    logic              dropped_oldest;
    logic [FILL_W-1:0] fill_count;
  } dcf_out_t;

endpackage

`default_nettype wire

// ----- hdl/dcf_ram.sv -----
`default_nettype none

module dcf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dcf_ctrl.sv -----
`default_nettype none

module dcf_ctrl #(
  parameter int DEPTH = dcf_pkg::DCF_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             accept,
  input  wire dcf_pkg::dcf_in_t                 in_data,
  input  wire logic                             cfg_we,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dcf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                  out_valid,
  output dcf_pkg::dcf_out_t                     res,
  output logic                                  ram_sel,
  output logic                                  ram_we,
  output logic      [$clog2(DEPTH)-1:0]         ram_waddr,
  output logic      [dcf_pkg::CODE_W-1:0]       ram_wdata,
  output logic                                  ram_re,
  output logic      [$clog2(DEPTH)-1:0]         ram_raddr
);

  import dcf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int FW = (PW + 1 > FILL_W) ? PW + 1 : FILL_W;
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTH_W   = (PW + 1)'(DEPTH);

  logic [MS_W-1:0]   filter_time_r;
  logic [MS_W-1:0]   pause_interval_r;
  logic [CODE_W-1:0] empty_code_r;
  logic [CODE_W-1:0] idle_code_r;

  logic [PW-1:0]     wp_r, wp_nxt;
  logic [PW-1:0]     rp_r, rp_nxt;
  logic [CODE_W-1:0] last_code_r, last_code_nxt;
  logic [MS_W-1:0]   elapsed_r, elapsed_nxt;
  logic              out_valid_r;
  dcf_out_t          res_r, res_nxt;
  logic              ram_sel_r, ram_sel_nxt;

  logic [MS_W-1:0]   elapsed_inc;
  logic [PW-1:0]     wp_step;
  logic [PW-1:0]     rp_step;
  logic              full;
  logic              empty;
  logic [PW:0]       fill;
  logic [FW-1:0]     fill_ext;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PW'(1);
  endfunction

  assign wp_step     = ring_next(wp_r);
  assign rp_step     = ring_next(rp_r);
  assign full        = (wp_step == rp_r);
  assign empty       = (wp_r == rp_r);
  assign elapsed_inc = (elapsed_r != MS_MAX) ? elapsed_r + MS_W'(1) : elapsed_r;

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    last_code_nxt = last_code_r;
    elapsed_nxt   = elapsed_r;
    ram_we        = 1'b0;
    ram_wdata     = in_data.code;
    ram_re        = 1'b0;
    ram_sel_nxt   = 1'b0;
    res_nxt       = '0;
    if (accept) begin
      case (in_data.mode)
        MODE_TICK: begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= pause_interval_r && !full) begin
            ram_we         = 1'b1;
            ram_wdata      = idle_code_r;
            wp_nxt         = wp_step;
            last_code_nxt  = idle_code_r;
            elapsed_nxt    = '0;
            res_nxt.pushed = 1'b1;
          end
        end
        MODE_CODE: begin
          if (in_data.code != last_code_r || elapsed_r > filter_time_r) begin
            ram_we                 = 1'b1;
            wp_nxt                 = wp_step;
            last_code_nxt          = in_data.code;
            res_nxt.pushed         = 1'b1;
            res_nxt.dropped_oldest = full;
            if (full) begin
              rp_nxt = rp_step;
            end
          end
          elapsed_nxt = '0;
        end
        MODE_READ: begin
          res_nxt.read_valid = 1'b1;
          if (empty) begin
            res_nxt.read_code = empty_code_r;
            res_nxt.was_empty = 1'b1;
          end else begin
            ram_re      = 1'b1;
            ram_sel_nxt = 1'b1;
            rp_nxt      = rp_step;
          end
        end
        default: begin
        end
      endcase
    end
    if (wp_nxt >= rp_nxt) begin
      fill = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      fill = {1'b0, wp_nxt} + DEPTH_W - {1'b0, rp_nxt};
    end
    fill_ext           = FW'(fill);
    res_nxt.fill_count = fill_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_time_r    <= FILTER_TIME_RST;
      pause_interval_r <= PAUSE_INTERVAL_RST;
      empty_code_r     <= EMPTY_CODE_RST;
      idle_code_r      <= IDLE_CODE_RST;
      wp_r             <= '0;
      rp_r             <= '0;
      last_code_r      <= '0;
      elapsed_r        <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FILTER_TIME:    filter_time_r    <= cfg_data[MS_W-1:0];
          REG_PAUSE_INTERVAL: pause_interval_r <= cfg_data[MS_W-1:0];
          REG_EMPTY_CODE:     empty_code_r     <= cfg_data[CODE_W-1:0];
          REG_IDLE_CODE:      idle_code_r      <= cfg_data[CODE_W-1:0];
          default: begin
          end
        endcase
      end
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      last_code_r <= last_code_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    ram_sel_r <= ram_sel_nxt;
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign ram_sel   = ram_sel_r;
  assign ram_waddr = wp_r;
  assign ram_raddr = rp_r;

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r <= LAST_SLOT) && (rp_r <= LAST_SLOT))
    else $error("Queue pointer left the ring.");

  a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.pushed |-> wp_r != rp_r)
    else $error("Queue is empty right after a push.");

  a_drop_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.dropped_oldest |-> res_r.pushed && !res_r.read_valid)
    else $error("Oldest entry dropped without a push.");

  a_code_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.mode == MODE_CODE |=> elapsed_r == '0)
    else $error("Elapsed counter not cleared by a received code.");

  a_ram_read_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ram_sel_r |-> res_r.read_valid && !res_r.was_empty && !res_r.pushed)
    else $error("Memory data selected for a transaction that is not a pop.");

endmodule

`default_nettype wire

// ----- hdl/dedup_code_fifo_with_keepalive.sv -----
// Channel  Ports                            Transfer
// -------  -------------------------------  ------------------------------------
// input    start, busy, in_data             start high and busy low at a clock edge
// result   out_valid, out_data              out_valid high for one cycle, no stall
// config   cfg_we, cfg_index, cfg_data      cfg_we high at a clock edge
//
// The result of every transaction appears in the cycle after it is taken.
// A new transaction may be started in every cycle, so the rate is one per clock.
// The queue memory read register also serves as the result register for pops.
// Reset is synchronous and active low; the queue memory needs no clearing pass.
// The receiver cannot stall, and busy stays low.
`default_nettype none

module dedup_code_fifo_with_keepalive #(
  parameter int DEPTH = dcf_pkg::DCF_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire dcf_pkg::dcf_in_t               in_data,
  output logic                                out_valid,
  output dcf_pkg::dcf_out_t                   out_data,
  input  wire logic                           cfg_we,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dcf_pkg::CFG_DATA_W-1:0] cfg_data
);

  import dcf_pkg::*;

  localparam int PW = $clog2(DEPTH);

  logic              accept;
  dcf_out_t          res;
  logic              ram_sel;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [CODE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [CODE_W-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  dcf_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .res       (res),
    .ram_sel   (ram_sel),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  dcf_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_comb begin
    out_data = res;
    if (ram_sel) begin
      out_data.read_code = ram_rdata;
    end
  end

endmodule

`default_nettype wire
